/* rtl/hsl_to_rgb_converter_assert.svh */
// Assertion macros for the HSL to RGB converter RTL.
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define H2R_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("hsl2rgb: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define H2R_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("hsl2rgb: next-cycle check failed");

`endif

/* rtl/hsl2rgb_pkg.sv */
// Types, constants and helper functions of the HSL to RGB converter.
package hsl2rgb_pkg;

	localparam int QW = 17;
	localparam logic [QW-1:0] Q_ONE   = 17'd65536;
	localparam logic [QW-1:0] Q_THIRD = 17'd21845;

	typedef logic [QW-1:0] q16_t;

	typedef enum logic [1:0] {
		SEG_RISE,
		SEG_TOP,
		SEG_FALL,
		SEG_LOW
	} seg_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	function automatic q16_t to_q16(input logic [15:0] x);
		return {1'b0, x} + q16_t'(x[15]);
	endfunction

	function automatic logic [7:0] to_chan(input q16_t c);
		logic [24:0] scaled;
		logic [8:0]  v;
		scaled = {c, 8'd0} - 25'(c);
		v = scaled[24:16];
		return (v > 9'd255) ? 8'd255 : v[7:0];
	endfunction

endpackage

/* rtl/hsl2rgb_channel.sv */
// One color channel: hue segment, slope multiply and scaling to 8 bits.
module hsl2rgb_channel (
	input  logic                clk,
	input  hsl2rgb_pkg::pipe_en_t en,
	input  hsl2rgb_pkg::q16_t   hue_q,
	input  hsl2rgb_pkg::q16_t   m1_s3,
	input  hsl2rgb_pkg::q16_t   m2_s3,
	input  hsl2rgb_pkg::q16_t   d_s3,
	input  logic                grey_s4,
	input  hsl2rgb_pkg::q16_t   light_s4,
	output logic [7:0]          chan
);
	import hsl2rgb_pkg::*;

	logic [18:0] six_h;
	seg_t        seg_d;
	q16_t        f_d;
	seg_t        seg_s2, seg_s3, seg_s4;
	q16_t        f_s2, f_s3;
	q16_t        m1_s4, m2_s4, prod_s4;
	logic [33:0] prod;
	logic [17:0] rise_sum;
	q16_t        level;
	logic [7:0]  chan_s5;

	assign six_h = 19'(hue_q) * 19'd6;

	always_comb begin
		if (six_h < 19'(Q_ONE)) begin
			seg_d = SEG_RISE;
			f_d   = six_h[16:0];
		end else if (hue_q < 17'd32768) begin
			seg_d = SEG_TOP;
			f_d   = '0;
		end else if ((19'(hue_q) * 19'd3) < 19'd131072) begin
			seg_d = SEG_FALL;
			f_d   = 17'(19'd262144 - six_h);
		end else begin
			seg_d = SEG_LOW;
			f_d   = '0;
		end
	end

	assign prod = 34'(d_s3) * 34'(f_s3);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			seg_s2 <= seg_d;
			f_s2   <= f_d;
		end
		if (en.s3) begin
			seg_s3 <= seg_s2;
			f_s3   <= f_s2;
		end
		if (en.s4) begin
			seg_s4  <= seg_s3;
			m1_s4   <= m1_s3;
			m2_s4   <= m2_s3;
			prod_s4 <= prod[32:16];
		end
	end

	assign rise_sum = 18'(m1_s4) + 18'(prod_s4);

	always_comb begin
		unique case (seg_s4)
			SEG_RISE, SEG_FALL: level = rise_sum[16:0];
			SEG_TOP:            level = m2_s4;
			SEG_LOW:            level = m1_s4;
			default:            level = m1_s4;
		endcase
		if (grey_s4)
			level = light_s4;
	end

	always_ff @(posedge clk) begin
		if (en.s5)
			chan_s5 <= to_chan(level);
	end

	assign chan = chan_s5;

endmodule

/* rtl/hsl_to_rgb_converter.sv */
// Top level of the HSL to RGB converter: pipeline control and level math.
//
// Usage:
//   Input channel hsl_valid / hsl_stall carries hue, saturation and
//   lightness, each a 16-bit unsigned fraction of full scale. Output
//   channel rgb_valid / rgb_stall carries 8-bit red, green and blue.
//   A beat moves at a rising edge with valid high and stall low.
// Pipeline and throughput:
//   Five register stages; one beat per cycle is sustained while
//   rgb_stall stays low. The stage count is set by the two multiplies
//   in series (lightness times saturation, then level span times hue
//   slope) and the output scale.
// Stalls:
//   When rgb_stall holds a waiting result, earlier stages still advance
//   into empty slots; hsl_stall rises only once every stage is full.
//   Nothing is dropped or repeated.
// Reset:
//   arst_n low clears all stage valid bits; the output is empty after it.
module hsl_to_rgb_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        hsl_valid,
	output logic        hsl_stall,
	input  logic [15:0] hue,
	input  logic [15:0] saturation,
	input  logic [15:0] lightness,
	output logic        rgb_valid,
	input  logic        rgb_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);
	import hsl2rgb_pkg::*;

	pipe_en_t    en;
	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	q16_t        h_s1, s_s1, l_s1;
	logic        grey_s1, grey_s2, grey_s3, grey_s4, grey_s5;
	q16_t        s_s2, l_s2, p_s2, l_s3, l_s4;
	q16_t        m1_s3, m2_s3, d_s3;
	logic [33:0] ls_prod;
	logic [17:0] m2_sum, m1_wide;
	q16_t        m2_d, m1_d;
	logic [17:0] hue_up;
	q16_t        hue_r, hue_b;

	assign en.s5 = !v_s5 || !rgb_stall;
	assign en.s4 = !v_s4 || en.s5;
	assign en.s3 = !v_s3 || en.s4;
	assign en.s2 = !v_s2 || en.s3;
	assign en.s1 = !v_s1 || en.s2;
	assign hsl_stall = !en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= hsl_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
		end
	end

	assign ls_prod = 34'(l_s1) * 34'(s_s1);

	assign hue_up = 18'(h_s1) + 18'(Q_THIRD);
	assign hue_r  = (hue_up > 18'(Q_ONE)) ? 17'(hue_up - 18'(Q_ONE)) : hue_up[16:0];
	assign hue_b  = (h_s1 < Q_THIRD) ? 17'(18'(h_s1) + 18'(Q_ONE) - 18'(Q_THIRD))
	                                 : (h_s1 - Q_THIRD);

	always_comb begin
		if (l_s2 < 17'd32768)
			m2_sum = 18'(l_s2) + 18'(p_s2);
		else
			m2_sum = 18'(l_s2) + 18'(s_s2) - 18'(p_s2);
		m2_d    = (m2_sum > 18'(Q_ONE)) ? Q_ONE : m2_sum[16:0];
		m1_wide = {l_s2, 1'b0} - 18'(m2_d);
		m1_d    = m1_wide[17] ? '0 : m1_wide[16:0];
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			h_s1    <= to_q16(hue);
			s_s1    <= to_q16(saturation);
			l_s1    <= to_q16(lightness);
			grey_s1 <= (saturation == 16'd0);
		end
		if (en.s2) begin
			s_s2    <= s_s1;
			l_s2    <= l_s1;
			p_s2    <= ls_prod[32:16];
			grey_s2 <= grey_s1;
		end
		if (en.s3) begin
			m1_s3   <= m1_d;
			m2_s3   <= m2_d;
			d_s3    <= (m2_d > m1_d) ? (m2_d - m1_d) : '0;
			l_s3    <= l_s2;
			grey_s3 <= grey_s2;
		end
		if (en.s4) begin
			l_s4    <= l_s3;
			grey_s4 <= grey_s3;
		end
		if (en.s5)
			grey_s5 <= grey_s4;
	end

	hsl2rgb_channel u_red (
		.clk      (clk),
		.en       (en),
		.hue_q    (hue_r),
		.m1_s3    (m1_s3),
		.m2_s3    (m2_s3),
		.d_s3     (d_s3),
		.grey_s4  (grey_s4),
		.light_s4 (l_s4),
		.chan     (red)
	);

	hsl2rgb_channel u_green (
		.clk      (clk),
		.en       (en),
		.hue_q    (h_s1),
		.m1_s3    (m1_s3),
		.m2_s3    (m2_s3),
		.d_s3     (d_s3),
		.grey_s4  (grey_s4),
		.light_s4 (l_s4),
		.chan     (green)
	);

	hsl2rgb_channel u_blue (
		.clk      (clk),
		.en       (en),
		.hue_q    (hue_b),
		.m1_s3    (m1_s3),
		.m2_s3    (m2_s3),
		.d_s3     (d_s3),
		.grey_s4  (grey_s4),
		.light_s4 (l_s4),
		.chan     (blue)
	);

	assign rgb_valid = v_s5;

`include "hsl_to_rgb_converter_assert.svh"

	`H2R_ASSERT_IMPLY(a_grey_equal, clk, arst_n, v_s5 && grey_s5, (red == green) && (green == blue))
	`H2R_ASSERT_IMPLY(a_stall_full, clk, arst_n, hsl_stall,
		v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && rgb_stall)
	`H2R_ASSERT_IMPLY(a_level_span, clk, arst_n, v_s3, (18'(m1_s3) + 18'(d_s3)) == 18'(m2_s3))
	`H2R_ASSERT_NEXT(a_stage_fill, clk, arst_n, v_s4 && en.s5, rgb_valid)

endmodule
